// ----- rtl/core/reversible_deque_assert.svh -----
// assertion macros used by the checker file
`ifndef REVERSIBLE_DEQUE_ASSERT_SVH
`define REVERSIBLE_DEQUE_ASSERT_SVH

// immediate-cycle implication, checked on every rising edge out of reset
`define RDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rdq_pkg.sv -----
// ----------------------------------------------------------------------------
// rdq_pkg
// types, sizes and codes shared by the reversible deque files
// ----------------------------------------------------------------------------
package rdq_pkg;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]                   operation;
    logic signed [WORD_WIDTH-1:0] value;
  } rdq_in_t;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] popped_word;
    logic [1:0]                   status;
    logic [CNT_W-1:0]             occupancy;
  } rdq_out_t;

  // store access issued for one transaction
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
  } rdq_mem_req_t;

  // per-transaction outcome, known at acceptance
  typedef struct packed {
    logic             pop_ok;
    logic [1:0]       status;
    logic [CNT_W-1:0] occupancy;
  } rdq_info_t;

endpackage

// ----- rtl/core/rdq_ram.sv -----
// ----------------------------------------------------------------------------
// rdq_ram
// single-port synchronous ram, registered read data held between reads
// ----------------------------------------------------------------------------
module rdq_ram #(
  parameter int unsigned DEPTH_P = 256,
  parameter int unsigned WIDTH_P = 32,
  localparam int unsigned AW     = $clog2(DEPTH_P)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic               re_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [WIDTH_P-1:0] wdata_i,
  output logic [WIDTH_P-1:0] rdata_o
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/rdq_ptr.sv -----
// ----------------------------------------------------------------------------
// rdq_ptr
// ring pointers, fill count and direction flag; picks the store slot
// ----------------------------------------------------------------------------
module rdq_ptr import rdq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [2:0]   op_i,
  output rdq_mem_req_t req_o,
  output rdq_info_t    info_o
);

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]    DEPTH_W   = (CNT_W + 1)'(DEPTH);

  logic [ADDR_W-1:0] first_q, first_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              rev_q, rev_d;

  logic              full, empty;
  logic [ADDR_W-1:0] first_dec, first_inc, end_slot, high_slot;
  logic [CNT_W:0]    end_sum;

  assign full  = (count_q == FULL_CNT);
  assign empty = (count_q == '0);

  assign first_dec = (first_q == '0) ? LAST_SLOT : first_q - 1'b1;
  assign first_inc = (first_q == LAST_SLOT) ? '0 : first_q + 1'b1;

  // one past the high end, wrapped by a single compare and subtract
  assign end_sum   = (CNT_W + 1)'(first_q) + (CNT_W + 1)'(count_q);
  assign end_slot  = (end_sum >= DEPTH_W) ? ADDR_W'(end_sum - DEPTH_W) : ADDR_W'(end_sum);
  assign high_slot = (end_slot == '0) ? LAST_SLOT : end_slot - 1'b1;

  always_comb begin
    first_d    = first_q;
    count_d    = count_q;
    rev_d      = rev_q;
    req_o      = '0;
    info_o     = '0;
    unique case (op_i) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          info_o.status = ST_FULL;
        end else begin
          req_o.wr_en = 1'b1;
          count_d     = count_q + 1'b1;
          if ((op_i == OP_PUSH_FRONT) != rev_q) begin
            first_d    = first_dec;
            req_o.addr = first_dec;
          end else begin
            req_o.addr = end_slot;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          info_o.status = ST_EMPTY;
        end else begin
          req_o.rd_en   = 1'b1;
          info_o.pop_ok = 1'b1;
          count_d       = count_q - 1'b1;
          if ((op_i == OP_POP_FRONT) != rev_q) begin
            first_d    = first_inc;
            req_o.addr = first_q;
          end else begin
            req_o.addr = high_slot;
          end
        end
      end
      OP_REVERSE: rev_d = ~rev_q;
      default: ;
    endcase
    info_o.occupancy = count_d;
    req_o.wr_en      = req_o.wr_en & accept_i;
    req_o.rd_en      = req_o.rd_en & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
    end else if (accept_i) begin
      first_q <= first_d;
      count_q <= count_d;
      rev_q   <= rev_d;
    end
  end

endmodule

// ----- rtl/core/reversible_deque.sv -----
// ----------------------------------------------------------------------------
// reversible_deque
// bounded double-ended queue of signed words in a ring store, with reversal
// ----------------------------------------------------------------------------
// usage:
// - input channel in_valid_i / in_ready_o carries one operation per transaction:
//   push front, push back, pop front, pop back or reverse, plus the word to push
// - output channel out_valid_o / out_ready_i returns exactly one result per
//   operation, in order: popped word (zero unless a pop succeeded), status
//   (done, pop on empty, push on full) and the number of words held afterwards
// - the store read is issued and the middle stage loads at the accepting edge;
//   the output register then loads from the middle stage and the read data
//   once it is free, and out_valid_o offers the result
// - throughput is one operation per cycle while the receiver keeps up; each operation moves
//   at most the front pointer and the count, and touches at most one entry of the single-port store
// - reads never collide with writes: an operation issues its store access at
//   its own acceptance edge, and a later pop of that slot reads at its own later edge
// - when the receiver stalls, the output register holds, the middle stage
//   fills, and in_ready_o drops until the output register drains
// - reset clears the pointers, the count, the direction flag and all valid
//   bits; the store itself is not cleared, only written slots are ever read
// ----------------------------------------------------------------------------
module reversible_deque import rdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rdq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rdq_out_t out_data_o
);

  logic                  accept;
  logic                  out_free;
  logic                  s1_adv;
  rdq_mem_req_t          mem_req;
  rdq_info_t             info;
  logic [WORD_WIDTH-1:0] rd_word;

  // middle stage: waits for the store read data
  logic      s1_valid_q, s1_valid_d;
  rdq_info_t s1_info_q;

  // output register
  logic     out_valid_q, out_valid_d;
  rdq_out_t out_data_q, out_data_d;

  // the output register frees when empty or taken this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;

  rdq_ptr u_ptr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (in_data_i.operation),
    .req_o    (mem_req),
    .info_o   (info)
  );

  // read data stays put while the middle stage stalls, since no new read
  // is issued until that stage moves on
  rdq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WORD_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.wr_en),
    .re_i    (mem_req.rd_en),
    .addr_i  (mem_req.addr),
    .wdata_i (in_data_i.value),
    .rdata_o (rd_word)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (s1_adv) begin
      out_valid_d            = 1'b1;
      out_data_d.popped_word = s1_info_q.pop_ok ? rd_word : '0;
      out_data_d.status      = s1_info_q.status;
      out_data_d.occupancy   = s1_info_q.occupancy;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= info;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/rdq_checker.sv -----
// ----------------------------------------------------------------------------
// rdq_checker
// port-level checks on the reversible deque, bound to the top level
// ----------------------------------------------------------------------------
`include "reversible_deque_assert.svh"

module rdq_checker import rdq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input rdq_out_t out_data_o
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // a stalled result stays offered
  `RDQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // an operation accepted while no result is offered must produce one after the middle stage
  `RDQ_ASSERT_NEXT(a_lat, clk_i, rst_ni, in_acc && !out_valid_o, ##1 out_valid_o, "missing result after transaction")

  // failed operations never return a word
  `RDQ_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_DONE, out_data_o.popped_word == '0, "failed operation returned data")

  // status agrees with occupancy
  `RDQ_ASSERT_NOW(a_full_occ, clk_i, rst_ni, out_valid_o && out_data_o.status == ST_FULL, out_data_o.occupancy == FULL_CNT, "full status with room left")
  `RDQ_ASSERT_NOW(a_empty_occ, clk_i, rst_ni, out_valid_o && out_data_o.status == ST_EMPTY, out_data_o.occupancy == '0, "empty status with words held")

endmodule

bind reversible_deque rdq_checker u_rdq_checker (.*);
